FILE: design/bqe_pkg.sv
package bqe_pkg;

  // Field widths of the particle and vertex beats
  localparam int POS_W     = 32;
  localparam int COLOR_W   = 16;
  localparam int LIFE_W    = 16;
  localparam int ALPHA_W   = 16;
  localparam int CORNER_W  = 2;

  // Configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int QSIZE_W   = 31;
  localparam int BASIS_W   = 32;

  // Alpha divider: quotient bits, split evenly over the pipeline stages
  localparam int ALPHA_FRAC = 15;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = ALPHA_FRAC / DIV_STEPS;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(32768);
  localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(8192);

  // Corner codes, in emission order
  localparam int QUAD_CORNERS = 4;
  localparam logic [CORNER_W-1:0] CORNER_ORIGIN  = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_UP      = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_SIDE_UP = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_SIDE    = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_X    = 3'd0,
    REG_VIEW_Y    = 3'd1,
    REG_VIEW_Z    = 3'd2,
    REG_UP_X      = 3'd3,
    REG_UP_Y      = 3'd4,
    REG_UP_Z      = 3'd5,
    REG_QUAD_SIZE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [COLOR_W-1:0] color_r;
    logic signed [COLOR_W-1:0] color_g;
    logic signed [COLOR_W-1:0] color_b;
    logic [LIFE_W-1:0]         life_left;
    logic [LIFE_W-1:0]         life_full;
    logic                      last_particle;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   vert_x;
    logic signed [POS_W-1:0]   vert_y;
    logic signed [POS_W-1:0]   vert_z;
    logic signed [COLOR_W-1:0] red;
    logic signed [COLOR_W-1:0] green;
    logic signed [COLOR_W-1:0] blue;
    logic [ALPHA_W-1:0]        alpha;
    logic [CORNER_W-1:0]       corner;
    logic                      quad_last;
    logic                      frame_last;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic                    ready;
    logic [2:0][BASIS_W-1:0] side;
    logic [2:0][BASIS_W-1:0] upw;
  } basis_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_XMUL,
    BS_XACC,
    BS_DOWN,
    BS_UP,
    BS_SQMUL,
    BS_SQACC,
    BS_ROOT,
    BS_NMUL,
    BS_DLOAD,
    BS_DIV,
    BS_STORE
  } bstate_t;

  // Cyclic axis successors for the cross products
  function automatic logic [1:0] axis_next(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] axis_far(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: design/bqe_basis.sv
module bqe_basis (
  input  logic             clk,
  input  logic             rst_n,
  input  bqe_pkg::cfg_wr_t cfg,
  output bqe_pkg::basis_t  basis
);

  localparam int CW = bqe_pkg::BASIS_W;
  localparam int AW = 2 * CW;

  logic signed [CW-1:0] view_r [3];
  logic signed [CW-1:0] up_r   [3];
  logic [bqe_pkg::QSIZE_W-1:0] qsize_r;

  bqe_pkg::bstate_t st_r, st_nxt;
  logic [2:0] k_r;
  logic       pass_r;
  logic [4:0] cnt_r;

  logic signed [AW-1:0] vec_r [3];
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] prod_r;
  logic signed [CW-1:0] sdn_r  [3];
  logic signed [CW-1:0] uwn_r  [3];
  logic signed [CW-1:0] side_r [3];
  logic signed [CW-1:0] upw_r  [3];

  logic [AW-1:0] n_r, res_r, bit_r;
  logic [CW-1:0] len_r;
  logic [CW:0]   rem_r;
  logic [CW-1:0] dvd_r, quo_r;

  logic [1:0] jx, ax1, ax2, ci;
  logic       term;
  logic signed [CW-1:0] mul_a, mul_b, comp;
  logic [CW-1:0] cmag;
  logic big, tiny_vec;
  logic [AW-1:0] trial, res_step, n_step;
  logic          root_take;
  logic [CW:0]   dtrial;
  logic          div_take;
  logic [AW-1:0] dsum;
  logic signed [AW-1:0] xval;
  logic signed [CW-1:0] sval;

  function automatic logic [AW-1:0] mag64(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  assign jx   = k_r[2:1];
  assign term = k_r[0];
  assign ax1  = bqe_pkg::axis_next(jx);
  assign ax2  = bqe_pkg::axis_far(jx);
  assign ci   = k_r[1:0];
  assign comp = pass_r ? uwn_r[ci] : sdn_r[ci];
  assign cmag = comp[CW-1] ? CW'(-comp) : CW'(comp);

  // Range checks over the working vector
  always_comb begin
    logic any_nz;
    logic all_lo;
    big    = 1'b0;
    any_nz = 1'b0;
    all_lo = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (mag64(vec_r[i]) >= (AW'(1) << 30)) big = 1'b1;
      if (mag64(vec_r[i]) >= (AW'(1) << 29)) all_lo = 1'b0;
      if (vec_r[i] != '0) any_nz = 1'b1;
    end
    tiny_vec = any_nz && all_lo;
  end

  // Square-root and divide step logic
  assign trial     = res_r + bit_r;
  assign root_take = (n_r >= trial);
  assign res_step  = root_take ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign n_step    = root_take ? (n_r - trial) : n_r;
  assign dtrial    = {rem_r[CW-1:0], dvd_r[CW-1]};
  assign div_take  = (dtrial >= {1'b0, len_r});
  assign dsum      = AW'(prod_r) + AW'(len_r >> 1);
  assign xval      = pass_r ? prod_r : (prod_r >>> 1);
  assign sval      = (len_r == '0) ? '0 : (comp[CW-1] ? -signed'(quo_r) : signed'(quo_r));

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      bqe_pkg::BS_XMUL: begin
        if (!pass_r) begin
          mul_a = term ? up_r[ax2]   : up_r[ax1];
          mul_b = term ? view_r[ax1] : view_r[ax2];
        end else begin
          mul_a = term ? view_r[ax2] : view_r[ax1];
          mul_b = term ? sdn_r[ax1]  : sdn_r[ax2];
        end
      end
      bqe_pkg::BS_SQMUL: begin
        mul_a = signed'(cmag);
        mul_b = signed'(cmag);
      end
      bqe_pkg::BS_NMUL: begin
        mul_a = signed'(cmag);
        mul_b = signed'({1'b0, qsize_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    basis.ready = (st_r == bqe_pkg::BS_IDLE);
    for (int i = 0; i < 3; i++) begin
      basis.side[i] = side_r[i];
      basis.upw[i]  = upw_r[i];
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bqe_pkg::BS_IDLE:  st_nxt = bqe_pkg::BS_IDLE;
      bqe_pkg::BS_XMUL:  st_nxt = bqe_pkg::BS_XACC;
      bqe_pkg::BS_XACC:  st_nxt = (k_r == 3'd5) ? bqe_pkg::BS_DOWN : bqe_pkg::BS_XMUL;
      bqe_pkg::BS_DOWN:  st_nxt = big ? bqe_pkg::BS_DOWN : bqe_pkg::BS_UP;
      bqe_pkg::BS_UP: begin
        if (tiny_vec) st_nxt = bqe_pkg::BS_UP;
        else          st_nxt = pass_r ? bqe_pkg::BS_SQMUL : bqe_pkg::BS_XMUL;
      end
      bqe_pkg::BS_SQMUL: st_nxt = bqe_pkg::BS_SQACC;
      bqe_pkg::BS_SQACC: st_nxt = (k_r == 3'd2) ? bqe_pkg::BS_ROOT : bqe_pkg::BS_SQMUL;
      bqe_pkg::BS_ROOT:  st_nxt = (cnt_r == 5'd31) ? bqe_pkg::BS_NMUL : bqe_pkg::BS_ROOT;
      bqe_pkg::BS_NMUL:  st_nxt = bqe_pkg::BS_DLOAD;
      bqe_pkg::BS_DLOAD: st_nxt = bqe_pkg::BS_DIV;
      bqe_pkg::BS_DIV:   st_nxt = (cnt_r == 5'd31) ? bqe_pkg::BS_STORE : bqe_pkg::BS_DIV;
      bqe_pkg::BS_STORE: begin
        if (k_r != 3'd2) st_nxt = bqe_pkg::BS_NMUL;
        else             st_nxt = pass_r ? bqe_pkg::BS_IDLE : bqe_pkg::BS_SQMUL;
      end
      default:           st_nxt = bqe_pkg::BS_IDLE;
    endcase
    if (cfg.we) st_nxt = bqe_pkg::BS_XMUL;
  end

  // Registers and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r[0] <= '0;
      view_r[1] <= '0;
      view_r[2] <= CW'(65536);
      up_r[0]   <= '0;
      up_r[1]   <= CW'(65536);
      up_r[2]   <= '0;
      qsize_r   <= bqe_pkg::QSIZE_W'(65536);
      st_r      <= bqe_pkg::BS_XMUL;
      k_r       <= '0;
      pass_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg.we) begin
        k_r    <= '0;
        pass_r <= 1'b0;
        unique case (bqe_pkg::reg_idx_t'(cfg.idx))
          bqe_pkg::REG_VIEW_X:    view_r[0] <= signed'(cfg.data);
          bqe_pkg::REG_VIEW_Y:    view_r[1] <= signed'(cfg.data);
          bqe_pkg::REG_VIEW_Z:    view_r[2] <= signed'(cfg.data);
          bqe_pkg::REG_UP_X:      up_r[0]   <= signed'(cfg.data);
          bqe_pkg::REG_UP_Y:      up_r[1]   <= signed'(cfg.data);
          bqe_pkg::REG_UP_Z:      up_r[2]   <= signed'(cfg.data);
          bqe_pkg::REG_QUAD_SIZE: qsize_r   <= cfg.data[bqe_pkg::QSIZE_W-1:0];
          default: ;
        endcase
      end else begin
        unique case (st_r)
          bqe_pkg::BS_XACC:  k_r <= (k_r == 3'd5) ? 3'd0 : k_r + 3'd1;
          bqe_pkg::BS_UP: begin
            if (!tiny_vec) begin
              k_r    <= '0;
              pass_r <= ~pass_r;
            end
          end
          bqe_pkg::BS_SQACC: begin
            k_r   <= (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
            cnt_r <= '0;
          end
          bqe_pkg::BS_ROOT:  cnt_r <= cnt_r + 5'd1;
          bqe_pkg::BS_DLOAD: cnt_r <= '0;
          bqe_pkg::BS_DIV:   cnt_r <= cnt_r + 5'd1;
          bqe_pkg::BS_STORE: begin
            if (k_r != 3'd2) begin
              k_r <= k_r + 3'd1;
            end else begin
              k_r    <= '0;
              pass_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (st_r)
      bqe_pkg::BS_XACC: begin
        if (!term) acc_r <= xval;
        else       vec_r[jx] <= acc_r - xval;
      end
      bqe_pkg::BS_DOWN: begin
        if (big) for (int i = 0; i < 3; i++) vec_r[i] <= vec_r[i] >>> 1;
      end
      bqe_pkg::BS_UP: begin
        if (tiny_vec) begin
          for (int i = 0; i < 3; i++) vec_r[i] <= vec_r[i] <<< 1;
        end else if (!pass_r) begin
          for (int i = 0; i < 3; i++) sdn_r[i] <= vec_r[i][CW-1:0];
        end else begin
          for (int i = 0; i < 3; i++) uwn_r[i] <= vec_r[i][CW-1:0];
        end
      end
      bqe_pkg::BS_SQACC: begin
        acc_r <= (k_r == 3'd0) ? prod_r : acc_r + prod_r;
        if (k_r == 3'd2) begin
          n_r   <= AW'(acc_r + prod_r);
          res_r <= '0;
          bit_r <= AW'(1) << (AW - 2);
        end
      end
      bqe_pkg::BS_ROOT: begin
        n_r   <= n_step;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (cnt_r == 5'd31) len_r <= res_step[CW-1:0];
      end
      bqe_pkg::BS_DLOAD: begin
        rem_r <= {1'b0, dsum[AW-1:CW]};
        dvd_r <= dsum[CW-1:0];
        quo_r <= '0;
      end
      bqe_pkg::BS_DIV: begin
        rem_r <= div_take ? (dtrial - {1'b0, len_r}) : dtrial;
        dvd_r <= dvd_r << 1;
        quo_r <= {quo_r[CW-2:0], div_take};
      end
      bqe_pkg::BS_STORE: begin
        if (!pass_r) side_r[ci] <= sval;
        else         upw_r[ci]  <= sval;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/billboard_quad_expander.sv
// Billboard quad expander: turns each particle into four camera-facing corners.
//
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one register per
// beat (view x,y,z, up x,y,z, quad size). cfg_ready is always high. Any write
// restarts the basis unit, which forms side = up x view and upward = view x side,
// range-normalizes them and scales each to the quad size with a shared 32x32
// multiplier, a bit-serial square root and a bit-serial divider. That run
// includes two 32-step roots and six 32-step divides; busy stays high until
// it finishes. Reset loads the default registers and runs the same
// computation before the first particle is taken.
//
// Particles: a particle beat is taken when start is high and busy is low. The
// result channel emits four corner beats on consecutive cycles, each marked by
// a one-cycle out_valid strobe: origin, up, side plus up, side. The first corner
// appears after the stage-0, divider, serializer and output registers. The
// one-beat-per-cycle result port sets the sustained rate; busy is held after
// each accept while the corner slot is taken. The alpha divider runs as a
// 5-stage pipeline. The receiver cannot stall, so no result is ever held back.
module billboard_quad_expander (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  bqe_pkg::in_t                      in_data,
  output logic                              out_valid,
  output bqe_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bqe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqe_pkg::CFG_W-1:0]         cfg_data
);

  localparam int PW = bqe_pkg::POS_W;
  localparam int LW = bqe_pkg::LIFE_W;
  localparam int QF = bqe_pkg::ALPHA_FRAC;
  localparam int NS = bqe_pkg::DIV_STAGES;

  // Per-stage payload of the particle pipeline
  typedef struct packed {
    bqe_pkg::in_t        item;
    logic [LW:0]         rem;
    logic [QF-1:0]       quo;
    logic                sat;
    logic [2:0][PW-1:0]  p_up;
    logic [2:0][PW-1:0]  p_side;
    logic [2:0][PW-1:0]  p_su;
  } pipe_t;

  bqe_pkg::cfg_wr_t cfg_wr;
  bqe_pkg::basis_t  basis;

  logic           accept;
  logic [1:0]     gap_r;
  logic           vld_r [NS+1];
  pipe_t          pipe_r [NS+1];
  pipe_t          pipe_nxt [NS+1];

  logic           ser_act_r;
  logic [1:0]     ser_cnt_r;
  pipe_t          ser_r;
  logic [bqe_pkg::ALPHA_W-1:0] ser_alpha_r;
  logic [bqe_pkg::ALPHA_W-1:0] alpha_nxt;
  bqe_pkg::out_t  out_r, out_nxt;
  logic           out_valid_r;

  assign cfg_ready   = 1'b1;
  assign cfg_wr.we   = cfg_valid && cfg_ready;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_data;

  bqe_basis u_basis (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .basis (basis)
  );

  // Hold busy while the basis is being rebuilt or the corner slot is taken
  assign busy   = !basis.ready || (gap_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (accept) begin
      gap_r <= 2'(bqe_pkg::QUAD_CORNERS - 1);
    end else if (gap_r != 2'd0) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  // Stage 0: register the beat, decide saturation, form the single-vector sums
  always_comb begin
    logic [2:0][PW-1:0] pos;
    pos[0] = in_data.pos_x;
    pos[1] = in_data.pos_y;
    pos[2] = in_data.pos_z;
    pipe_nxt[0]      = '0;
    pipe_nxt[0].item = in_data;
    pipe_nxt[0].rem  = {1'b0, in_data.life_left};
    pipe_nxt[0].quo  = '0;
    pipe_nxt[0].sat  = (in_data.life_full == '0) || (in_data.life_left >= in_data.life_full);
    for (int i = 0; i < 3; i++) begin
      pipe_nxt[0].p_up[i]   = pos[i] + PW'(signed'(basis.upw[i]));
      pipe_nxt[0].p_side[i] = pos[i] + PW'(signed'(basis.side[i]));
    end
  end

  // Stages 1..NS: three restoring-divide steps each; stage 1 also adds upward
  // onto the side corner
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_comb begin
      logic [LW:0] r;
      logic [QF-1:0] q;
      pipe_nxt[s] = pipe_r[s-1];
      r = pipe_r[s-1].rem;
      q = pipe_r[s-1].quo;
      for (int t = 0; t < bqe_pkg::DIV_STEPS; t++) begin
        r = {r[LW-1:0], 1'b0};
        if (r >= {1'b0, pipe_r[s-1].item.life_full}) begin
          r = r - {1'b0, pipe_r[s-1].item.life_full};
          q = {q[QF-2:0], 1'b1};
        end else begin
          q = {q[QF-2:0], 1'b0};
        end
      end
      pipe_nxt[s].rem = r;
      pipe_nxt[s].quo = q;
      if (s == 1) begin
        for (int i = 0; i < 3; i++) begin
          pipe_nxt[s].p_su[i] = pipe_r[s-1].p_side[i] + PW'(signed'(basis.upw[i]));
        end
      end
    end
  end

  for (genvar s = 0; s <= NS; s++) begin : g_preg
    if (s == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[s] <= 1'b0;
        else        vld_r[s] <= accept;
        pipe_r[s] <= pipe_nxt[s];
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[s] <= 1'b0;
        else        vld_r[s] <= vld_r[s-1];
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  // Raise alpha to the quarter floor; full or overlong life, or zero life_full, gives one
  always_comb begin
    if (pipe_r[NS].sat) begin
      alpha_nxt = bqe_pkg::ALPHA_ONE;
    end else if (bqe_pkg::ALPHA_W'(pipe_r[NS].quo) < bqe_pkg::ALPHA_MIN) begin
      alpha_nxt = bqe_pkg::ALPHA_MIN;
    end else begin
      alpha_nxt = bqe_pkg::ALPHA_W'(pipe_r[NS].quo);
    end
  end

  // Corner serializer: load a finished particle, advance one corner per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_act_r <= 1'b0;
      ser_cnt_r <= '0;
    end else if (vld_r[NS]) begin
      ser_act_r <= 1'b1;
      ser_cnt_r <= bqe_pkg::CORNER_ORIGIN;
    end else if (ser_act_r) begin
      ser_act_r <= (ser_cnt_r != bqe_pkg::CORNER_SIDE);
      ser_cnt_r <= ser_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[NS]) begin
      ser_r       <= pipe_r[NS];
      ser_alpha_r <= alpha_nxt;
    end
  end

  always_comb begin
    logic [2:0][PW-1:0] v;
    unique case (ser_cnt_r)
      bqe_pkg::CORNER_ORIGIN: begin
        v[0] = ser_r.item.pos_x;
        v[1] = ser_r.item.pos_y;
        v[2] = ser_r.item.pos_z;
      end
      bqe_pkg::CORNER_UP:      v = ser_r.p_up;
      bqe_pkg::CORNER_SIDE_UP: v = ser_r.p_su;
      bqe_pkg::CORNER_SIDE:    v = ser_r.p_side;
    endcase
    out_nxt.vert_x     = v[0];
    out_nxt.vert_y     = v[1];
    out_nxt.vert_z     = v[2];
    out_nxt.red        = ser_r.item.color_r;
    out_nxt.green      = ser_r.item.color_g;
    out_nxt.blue       = ser_r.item.color_b;
    out_nxt.alpha      = ser_alpha_r;
    out_nxt.corner     = ser_cnt_r;
    out_nxt.quad_last  = (ser_cnt_r == bqe_pkg::CORNER_SIDE);
    out_nxt.frame_last = (ser_cnt_r == bqe_pkg::CORNER_SIDE) && ser_r.item.last_particle;
  end

  // Output register: one corner beat per cycle, strobed
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= ser_act_r;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
